// ===== rtl/core/tilp_pkg.sv =====
// ----------------------------------------------------------------------------
// tilp_pkg
// Shared types and constants of the task/ISR load profiler.
// ----------------------------------------------------------------------------
package tilp_pkg;

    localparam int TASK_COUNT_DEF = 16;
    localparam int ISR_COUNT_DEF  = 16;

    localparam int DVD_W = 40;   // value*100 fits in 39 bits
    localparam int DVS_W = 32;

    localparam logic [1:0] MODE_ENTER = 2'd0;
    localparam logic [1:0] MODE_EXIT  = 2'd1;
    localparam logic [1:0] MODE_TRIG  = 2'd2;

    typedef enum logic [2:0] {
        REC_ENTER = 3'd0,
        REC_EXIT  = 3'd1,
        REC_ENTRY = 3'd2,
        REC_SINCE = 3'd3,
        REC_LAST  = 3'd4,
        REC_BASE  = 3'd5
    } t_rec;

    typedef enum logic [2:0] {
        DIV_EV_TICKS,
        DIV_TR_TICKS,
        DIV_ENTRY,
        DIV_TASK_ALL,
        DIV_ISR_ALL,
        DIV_TASK_PER,
        DIV_ISR_PER
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_EN_WR, S_EX_GO, S_EX_W, S_EX_WR, S_BASE,
        S_TR_GO, S_TR_W, S_LP_RD, S_LP_GO, S_LP_W, S_LP_WR,
        S_SA_GO, S_SA_W, S_SB_GO, S_SB_W, S_S3,
        S_SC_GO, S_SC_W, S_SD_GO, S_SD_W, S_S4
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     rd_ev;
        logic     rd_loop;
        logic     div_go;
        t_div_sel div_sel;
        logic     wr_enter;
        logic     wr_exit;
        logic     wr_loop;
        logic     base_set;
        logic     tr_upd;
        logic     lat_tl;
        logic     lat_il;
        logic     emit;
        t_rec     rec;
        logic     last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       id_ok;
        logic       baseline;
        logic       div_done;
        logic       loop_end;
    } t_stat;

endpackage

// ===== rtl/core/task_isr_load_profiler_top.sv =====
// ----------------------------------------------------------------------------
// task_isr_load_profiler_top
// Execution-time and load profiler for tasks and interrupt service routines.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  request   start / busy           i_mode, i_entity_kind, i_entity_id,
//                                   i_timestamp
//  result    o_valid (1-cycle)      o_record_kind .. o_total_us, o_last
//  config    i_cfg_we               i_cfg_wdata (ticks per microsecond)
//
//  An enter needs no division; an exit waits for the 40-step divider.
//  A trigger walks the entry table, one division per entry; a baseline
//  trigger needs no division. Bad ids and mode 3 finish with no result.
//  Reset (i_rst_n low, synchronous) empties the table at once via per-entry
//  valid bits and sets ticks per microsecond to 1.
//  Results are strobed for one cycle and cannot be held off; busy drops in
//  the cycle that shows the last result of a request.
// ----------------------------------------------------------------------------
module task_isr_load_profiler_top #(
    parameter int TASK_COUNT = tilp_pkg::TASK_COUNT_DEF,
    parameter int ISR_COUNT  = tilp_pkg::ISR_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic        i_entity_kind,
    input  logic [4:0]  i_entity_id,
    input  logic [31:0] i_timestamp,
    output logic        o_valid,
    output logic [2:0]  o_record_kind,
    output logic        o_out_entity_kind,
    output logic [4:0]  o_out_entity_id,
    output logic [31:0] o_duration_us,
    output logic [7:0]  o_load_pct,
    output logic [7:0]  o_isr_load_pct,
    output logic [7:0]  o_total_load_pct,
    output logic [31:0] o_invoke_count,
    output logic [31:0] o_max_us,
    output logic [31:0] o_total_us,
    output logic        o_last
);
    import tilp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one request at a time
    tilp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // table, divider, sums and result registers
    tilp_dp #(.TASK_COUNT(TASK_COUNT), .ISR_COUNT(ISR_COUNT)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_mode            (i_mode),
        .i_entity_kind     (i_entity_kind),
        .i_entity_id       (i_entity_id),
        .i_timestamp       (i_timestamp),
        .o_valid           (o_valid),
        .o_record_kind     (o_record_kind),
        .o_out_entity_kind (o_out_entity_kind),
        .o_out_entity_id   (o_out_entity_id),
        .o_duration_us     (o_duration_us),
        .o_load_pct        (o_load_pct),
        .o_isr_load_pct    (o_isr_load_pct),
        .o_total_load_pct  (o_total_load_pct),
        .o_invoke_count    (o_invoke_count),
        .o_max_us          (o_max_us),
        .o_total_us        (o_total_us),
        .o_last            (o_last)
    );
endmodule

// ===== rtl/core/tilp_ram.sv =====
// ----------------------------------------------------------------------------
// tilp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tilp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/core/tilp_div.sv =====
// ----------------------------------------------------------------------------
// tilp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tilp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [tilp_pkg::DVD_W-1:0] i_dvd,
    input  logic [tilp_pkg::DVS_W-1:0] i_dvs,
    output logic                     o_done,
    output logic [tilp_pkg::DVD_W-1:0] o_quot
);
    import tilp_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem[DVS_W-1:0], r_q[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== rtl/core/tilp_dp.sv =====
// ----------------------------------------------------------------------------
// tilp_dp
// Datapath: entry table, divider, sums and result registers.
// ----------------------------------------------------------------------------
module tilp_dp #(
    parameter int TASK_COUNT = tilp_pkg::TASK_COUNT_DEF,
    parameter int ISR_COUNT  = tilp_pkg::ISR_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tilp_pkg::t_cmd     i_cmd,
    output tilp_pkg::t_stat    o_stat,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic [1:0]         i_mode,
    input  logic               i_entity_kind,
    input  logic [4:0]         i_entity_id,
    input  logic [31:0]        i_timestamp,
    output logic               o_valid,
    output logic [2:0]         o_record_kind,
    output logic               o_out_entity_kind,
    output logic [4:0]         o_out_entity_id,
    output logic [31:0]        o_duration_us,
    output logic [7:0]         o_load_pct,
    output logic [7:0]         o_isr_load_pct,
    output logic [7:0]         o_total_load_pct,
    output logic [31:0]        o_invoke_count,
    output logic [31:0]        o_max_us,
    output logic [31:0]        o_total_us,
    output logic               o_last
);
    import tilp_pkg::*;

    localparam int NENT = TASK_COUNT + ISR_COUNT;
    localparam int AW   = $clog2(NENT);
    localparam int RW   = 160;

    // inputs and config
    logic [7:0]  r_tpu;
    logic [1:0]  r_mode;
    logic        r_kind;
    logic [4:0]  r_id;
    logic [31:0] r_ts;
    logic        r_id_ok;
    logic [AW-1:0] r_ent;

    // global state
    logic        r_base;
    logic [31:0] r_last_ts;
    logic [31:0] r_elapsed;
    logic [31:0] r_interval;
    logic [AW-1:0] r_idx;
    logic [31:0] r_task_all, r_task_per, r_isr_all, r_isr_per;
    logic [31:0] r_idle_per, r_idle_life;
    logic [7:0]  r_tl, r_il;
    logic        r_div_zero;

    // table
    logic [NENT-1:0] r_vld;
    logic            r_rd_vld;
    logic [RW-1:0]   ram_q;
    logic [RW-1:0]   rd;
    logic [31:0]     e_start, e_max, e_per, e_life, e_inv;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [RW-1:0]   wdata;

    // divider
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic [DVD_W-1:0] quot;
    logic             div_done;
    logic [7:0]       ld;
    logic [31:0]      d_us;
    logic [31:0]      tick_div;

    // loop helpers
    logic        is_task;
    logic [31:0] life_new;
    logic [31:0] max_new;
    logic [8:0]  tsum;

    // output next values
    logic        n_ek;
    logic [4:0]  n_eid;
    logic [31:0] n_dur, n_inv, n_max, n_tot;
    logic [7:0]  n_ld, n_il, n_tl;

    tilp_ram #(.WIDTH(RW), .DEPTH(NENT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_ev | i_cmd.rd_loop),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    tilp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_dvd   (dvd),
        .i_dvs   (dvs),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // never-written entries read as zero
    assign rd = r_rd_vld ? ram_q : '0;
    assign {e_start, e_max, e_per, e_life, e_inv} = rd;

    assign tick_div = {24'd0, (r_tpu == 8'd0) ? 8'd1 : r_tpu};
    assign d_us     = quot[31:0];
    assign ld       = r_div_zero ? 8'd0 : ((|quot[DVD_W-1:8]) ? 8'd255 : quot[7:0]);
    assign is_task  = int'(r_idx) < TASK_COUNT;
    assign life_new = e_life + e_per;
    assign max_new  = (d_us > e_max) ? d_us : e_max;
    assign tsum     = {1'b0, r_tl} + {1'b0, r_il};

    // divider operands
    always_comb begin
        dvd = '0;
        dvs = '0;
        case (i_cmd.div_sel)
            DIV_EV_TICKS: begin dvd = {8'd0, r_ts - e_start};   dvs = tick_div;  end
            DIV_TR_TICKS: begin dvd = {8'd0, r_ts - r_last_ts}; dvs = tick_div;  end
            DIV_ENTRY:    begin dvd = {8'd0, e_per} * 40'd100;      dvs = r_interval; end
            DIV_TASK_ALL: begin dvd = {8'd0, r_task_all} * 40'd100; dvs = r_elapsed;  end
            DIV_ISR_ALL:  begin dvd = {8'd0, r_isr_all} * 40'd100;  dvs = r_elapsed;  end
            DIV_TASK_PER: begin dvd = {8'd0, r_task_per} * 40'd100; dvs = r_interval; end
            DIV_ISR_PER:  begin dvd = {8'd0, r_isr_per} * 40'd100;  dvs = r_interval; end
            default:      begin dvd = '0; dvs = '0; end
        endcase
    end

    // table write
    always_comb begin
        we    = i_cmd.wr_enter | i_cmd.wr_exit | i_cmd.wr_loop;
        waddr = i_cmd.wr_loop ? r_idx : r_ent;
        raddr = i_cmd.rd_loop ? r_idx : r_ent;
        if (i_cmd.wr_enter) begin
            wdata = {r_ts, e_max, e_per, e_life, e_inv + 32'd1};
        end else if (i_cmd.wr_exit) begin
            wdata = {e_start, max_new, e_per + d_us, e_life, e_inv};
        end else begin
            wdata = {e_start, e_max, 32'd0, life_new, e_inv};
        end
    end

    // result fields
    always_comb begin
        n_ek  = 1'b0;
        n_eid = '0;
        n_dur = '0;
        n_ld  = '0;
        n_il  = '0;
        n_tl  = '0;
        n_inv = '0;
        n_max = '0;
        n_tot = '0;
        case (i_cmd.rec)
            REC_ENTER: begin
                n_ek = r_kind; n_eid = r_id;
                n_inv = e_inv + 32'd1; n_max = e_max; n_tot = e_life;
            end
            REC_EXIT: begin
                n_ek = r_kind; n_eid = r_id; n_dur = d_us;
                n_inv = e_inv; n_max = max_new; n_tot = e_life;
            end
            REC_ENTRY: begin
                n_ek  = ~is_task;
                n_eid = is_task ? 5'(r_idx) : 5'(int'(r_idx) - TASK_COUNT);
                n_dur = e_per; n_ld = ld;
                n_inv = e_inv; n_max = e_max; n_tot = life_new;
            end
            REC_SINCE, REC_LAST: begin
                n_dur = (i_cmd.rec == REC_SINCE) ? r_elapsed : r_interval;
                n_ld  = r_tl;
                n_il  = r_il;
                n_tl  = tsum[8] ? 8'd255 : tsum[7:0];
                n_tot = (i_cmd.rec == REC_SINCE) ? r_idle_life : r_idle_per;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu     <= 8'd1;
            r_base    <= 1'b0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_last_ts <= '0;
            r_elapsed <= '0;
            r_idx     <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                r_tpu <= i_cfg_wdata;
            end
            if (i_cmd.rd_ev | i_cmd.rd_loop) begin
                r_rd_vld <= r_vld[raddr];
            end
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_cmd.base_set) begin
                r_base    <= 1'b1;
                r_last_ts <= r_ts;
            end
            if (i_cmd.tr_upd) begin
                r_elapsed <= r_elapsed + d_us;
                r_last_ts <= r_ts;
                r_idx     <= '0;
            end
            if (i_cmd.wr_loop) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= i_mode;
            r_kind  <= i_entity_kind;
            r_id    <= i_entity_id;
            r_ts    <= i_timestamp;
            r_id_ok <= i_entity_kind ? (int'(i_entity_id) < ISR_COUNT)
                                     : (int'(i_entity_id) < TASK_COUNT);
            r_ent   <= AW'(i_entity_kind ? TASK_COUNT + int'(i_entity_id)
                                         : int'(i_entity_id));
        end
        if (i_cmd.div_go) begin
            r_div_zero <= (dvs == '0);
        end
        if (i_cmd.tr_upd) begin
            r_interval <= d_us;
            r_task_all <= '0;
            r_task_per <= '0;
            r_isr_all  <= '0;
            r_isr_per  <= '0;
        end
        if (i_cmd.wr_loop) begin
            if (r_idx == '0) begin
                r_idle_per  <= e_per;
                r_idle_life <= life_new;
            end
            if (is_task) begin
                if (r_idx != '0) begin
                    r_task_all <= r_task_all + life_new;
                    r_task_per <= r_task_per + e_per;
                end
            end else begin
                r_isr_all <= r_isr_all + life_new;
                r_isr_per <= r_isr_per + e_per;
            end
        end
        if (i_cmd.lat_tl) begin
            r_tl <= ld;
        end
        if (i_cmd.lat_il) begin
            r_il <= ld;
        end
        if (i_cmd.emit) begin
            o_record_kind     <= i_cmd.rec;
            o_out_entity_kind <= n_ek;
            o_out_entity_id   <= n_eid;
            o_duration_us     <= n_dur;
            o_load_pct        <= n_ld;
            o_isr_load_pct    <= n_il;
            o_total_load_pct  <= n_tl;
            o_invoke_count    <= n_inv;
            o_max_us          <= n_max;
            o_total_us        <= n_tot;
            o_last            <= i_cmd.last;
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.id_ok    = r_id_ok;
    assign o_stat.baseline = r_base;
    assign o_stat.div_done = div_done;
    assign o_stat.loop_end = (r_idx == AW'(NENT - 1));
endmodule

// ===== rtl/core/tilp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tilp_ctrl
// Sequencer for enter, exit and trigger requests.
// ----------------------------------------------------------------------------
module tilp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tilp_pkg::t_stat i_stat,
    output tilp_pkg::t_cmd  o_cmd
);
    import tilp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_DEC;
            S_DEC: begin
                if ((i_stat.mode == MODE_ENTER) && i_stat.id_ok) begin
                    n_state = S_EN_WR;
                end else if ((i_stat.mode == MODE_EXIT) && i_stat.id_ok) begin
                    n_state = S_EX_GO;
                end else if (i_stat.mode == MODE_TRIG) begin
                    n_state = i_stat.baseline ? S_TR_GO : S_BASE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EN_WR: n_state = S_IDLE;
            S_EX_GO: n_state = S_EX_W;
            S_EX_W:  if (i_stat.div_done) n_state = S_EX_WR;
            S_EX_WR: n_state = S_IDLE;
            S_BASE:  n_state = S_IDLE;
            S_TR_GO: n_state = S_TR_W;
            S_TR_W:  if (i_stat.div_done) n_state = S_LP_RD;
            S_LP_RD: n_state = S_LP_GO;
            S_LP_GO: n_state = S_LP_W;
            S_LP_W:  if (i_stat.div_done) n_state = S_LP_WR;
            S_LP_WR: n_state = i_stat.loop_end ? S_SA_GO : S_LP_RD;
            S_SA_GO: n_state = S_SA_W;
            S_SA_W:  if (i_stat.div_done) n_state = S_SB_GO;
            S_SB_GO: n_state = S_SB_W;
            S_SB_W:  if (i_stat.div_done) n_state = S_S3;
            S_S3:    n_state = S_SC_GO;
            S_SC_GO: n_state = S_SC_W;
            S_SC_W:  if (i_stat.div_done) n_state = S_SD_GO;
            S_SD_GO: n_state = S_SD_W;
            S_SD_W:  if (i_stat.div_done) n_state = S_S4;
            S_S4:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_EV_TICKS;
        o_cmd.rec     = REC_ENTER;
        case (r_state)
            S_IDLE:  o_cmd.accept = start;
            S_DEC:   o_cmd.rd_ev  = 1'b1;
            S_EN_WR: begin
                o_cmd.wr_enter = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.rec      = REC_ENTER;
                o_cmd.last     = 1'b1;
            end
            S_EX_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_EV_TICKS;
            end
            S_EX_WR: begin
                o_cmd.wr_exit = 1'b1;
                o_cmd.emit    = 1'b1;
                o_cmd.rec     = REC_EXIT;
                o_cmd.last    = 1'b1;
            end
            S_BASE: begin
                o_cmd.base_set = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.rec      = REC_BASE;
                o_cmd.last     = 1'b1;
            end
            S_TR_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_TR_TICKS;
            end
            S_TR_W:  o_cmd.tr_upd = i_stat.div_done;
            S_LP_RD: o_cmd.rd_loop = 1'b1;
            S_LP_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_ENTRY;
            end
            S_LP_WR: begin
                o_cmd.wr_loop = 1'b1;
                o_cmd.emit    = 1'b1;
                o_cmd.rec     = REC_ENTRY;
            end
            S_SA_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_TASK_ALL;
            end
            S_SA_W:  o_cmd.lat_tl = i_stat.div_done;
            S_SB_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_ISR_ALL;
            end
            S_SB_W:  o_cmd.lat_il = i_stat.div_done;
            S_S3: begin
                o_cmd.emit = 1'b1;
                o_cmd.rec  = REC_SINCE;
            end
            S_SC_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_TASK_PER;
            end
            S_SC_W:  o_cmd.lat_tl = i_stat.div_done;
            S_SD_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_ISR_PER;
            end
            S_SD_W:  o_cmd.lat_il = i_stat.div_done;
            S_S4: begin
                o_cmd.emit = 1'b1;
                o_cmd.rec  = REC_LAST;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);
endmodule
